@@ rtl/core/hsv_to_rgb_converter_assert.svh @@
// Assertion macros used by the HSV to RGB converter RTL.
`ifndef HSV_TO_RGB_CONVERTER_ASSERT_SVH
`define HSV_TO_RGB_CONVERTER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HSV_ASSERT_IMPLIES(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("hsv_to_rgb_converter: implication violated");

// Expression must never be true out of reset.
`define HSV_ASSERT_NEVER(lbl, ck, rn, expr) \
    lbl: assert property (@(posedge ck) disable iff (!rn) !(expr)) \
        else $error("hsv_to_rgb_converter: forbidden condition seen");

`endif

@@ rtl/core/hsv_pkg.sv @@
// Shared types and fixed-point constants for the HSV to RGB converter.
`timescale 1ns / 1ps
`default_nettype none

package hsv_pkg;

    // Weight lost against full chroma, 0..3840 in 1/64 degree units.
    typedef logic [11:0] loss_t;
    typedef logic [7:0]  byte_t;

    localparam logic [11:0] SECTOR_UNITS = 12'd3840;
    localparam logic [14:0] FULL_TURN    = 15'd23040;
    // 255 * 3840: full scale of one channel numerator before scaling.
    localparam logic [19:0] FULL_SCALE   = 20'd979200;
    // After dropping 8 low bits the divisor left is 255 * 15.
    localparam logic [11:0] DIV_BY       = 12'd3825;
    // floor(2^32 / 3825); the estimate lands on q or q - 1.
    localparam logic [20:0] RECIP        = 21'd1122867;
    localparam int          RECIP_SHIFT  = 32;
    // Register stages inside one channel scaler.
    localparam int          CHAN_STAGES  = 4;

endpackage

`default_nettype wire

@@ rtl/core/hsv_chan_scale.sv @@
// Four-stage channel scaler: floor(V * (255*3840 - S*loss) / (255*3840)).
`timescale 1ns / 1ps
`default_nettype none

module hsv_chan_scale
(
    input  wire logic          clk,
    input  wire hsv_pkg::byte_t sat,
    input  wire hsv_pkg::byte_t val,
    input  wire hsv_pkg::loss_t loss,
    output hsv_pkg::byte_t      chan
);

    logic [19:0] sh_a_reg;
    logic [7:0]  val_a_reg;
    logic [19:0] x_b_reg;
    logic [7:0]  q0_c_reg;
    logic [19:0] x_c_reg;
    logic [7:0]  chan_reg;

    logic [19:0] sh_next;
    logic [19:0] diff;
    logic [27:0] num;
    logic [40:0] prod;
    logic [19:0] back;
    logic [19:0] rem;
    logic [7:0]  chan_next;

    always_comb
    begin
        sh_next   = 20'(sat * loss);
        diff      = hsv_pkg::FULL_SCALE - sh_a_reg;
        num       = 28'(val_a_reg * diff);
        prod      = 41'(x_b_reg * hsv_pkg::RECIP);
        back      = 20'(q0_c_reg * hsv_pkg::DIV_BY);
        rem       = x_c_reg - back;
        // bump the estimate when the remainder overflows one divisor
        chan_next = q0_c_reg + ((rem >= {8'd0, hsv_pkg::DIV_BY}) ? 8'd1 : 8'd0);
    end

    always_ff @(posedge clk)
    begin
        sh_a_reg  <= sh_next;
        val_a_reg <= val;
        x_b_reg   <= num[27:8];
        q0_c_reg  <= prod[hsv_pkg::RECIP_SHIFT +: 8];
        x_c_reg   <= x_b_reg;
        chan_reg  <= chan_next;
    end

    assign chan = chan_reg;

endmodule

`default_nettype wire

@@ rtl/core/hsv_to_rgb_converter.sv @@
// HSV to RGB converter: six-stage pipeline, one pixel per clock.
// done rises with the red, green, blue and alpha results; a pixel passes the hue
// wrap of stage 1, the loss weights of stage 2 and then the channel scalers.
// Throughput: one beat per clock; busy is always low, the pipe never stalls.
// The longest stages hold one 20x21 multiply (reciprocal) or one 8x20 multiply.
// Reset clears the valid bits only; data registers are not reset.
`timescale 1ns / 1ps
`default_nettype none

module hsv_to_rgb_converter
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [14:0] hue_angle,
    input  wire logic [7:0]  saturation,
    input  wire logic [7:0]  brightness,
    input  wire logic [7:0]  alpha_in,
    output logic             done,
    output logic [7:0]       red,
    output logic [7:0]       green,
    output logic [7:0]       blue,
    output logic [7:0]       alpha_out
);

    `include "hsv_to_rgb_converter_assert.svh"

    localparam logic [2:0] SEC_RED_YEL = 3'd0;
    localparam logic [2:0] SEC_YEL_GRN = 3'd1;
    localparam logic [2:0] SEC_GRN_CYN = 3'd2;
    localparam logic [2:0] SEC_CYN_BLU = 3'd3;
    localparam logic [2:0] SEC_BLU_MAG = 3'd4;
    localparam logic [2:0] SEC_MAG_RED = 3'd5;

    localparam int NDLY = hsv_pkg::CHAN_STAGES;
    // edges from the accepting edge to the one that takes the result
    localparam int LAT  = NDLY + 2;

    // stage 1: hue wrapped into one turn
    logic                  vld_s1_reg;
    logic [14:0]           hue_s1_reg;
    hsv_pkg::byte_t        sat_s1_reg;
    hsv_pkg::byte_t        val_s1_reg;
    hsv_pkg::byte_t        alpha_s1_reg;
    logic [14:0]           hue_next;

    // stage 2: per-channel loss weights
    logic                  vld_s2_reg;
    hsv_pkg::byte_t        sat_s2_reg;
    hsv_pkg::byte_t        val_s2_reg;
    hsv_pkg::byte_t        alpha_s2_reg;
    hsv_pkg::loss_t        loss_r_s2_reg;
    hsv_pkg::loss_t        loss_g_s2_reg;
    hsv_pkg::loss_t        loss_b_s2_reg;
    hsv_pkg::loss_t        loss_r_next;
    hsv_pkg::loss_t        loss_g_next;
    hsv_pkg::loss_t        loss_b_next;
    logic [2:0]            sector;
    logic [14:0]           base;
    logic [14:0]           pos;
    hsv_pkg::loss_t        frac;
    hsv_pkg::loss_t        rise_loss;

    // stages 3..6: valid and alpha follow the channel scalers
    logic [NDLY-1:0]       vld_dly_reg;
    hsv_pkg::byte_t        alpha_dly_reg [NDLY];

    assign busy = 1'b0;

    always_comb
    begin
        if (hue_angle >= hsv_pkg::FULL_TURN)
        begin
            hue_next = hue_angle - hsv_pkg::FULL_TURN;
        end
        else
        begin
            hue_next = hue_angle;
        end
    end

    always_comb
    begin
        if (hue_s1_reg >= 15'd19200)
        begin
            sector = SEC_MAG_RED;
            base   = 15'd19200;
        end
        else if (hue_s1_reg >= 15'd15360)
        begin
            sector = SEC_BLU_MAG;
            base   = 15'd15360;
        end
        else if (hue_s1_reg >= 15'd11520)
        begin
            sector = SEC_CYN_BLU;
            base   = 15'd11520;
        end
        else if (hue_s1_reg >= 15'd7680)
        begin
            sector = SEC_GRN_CYN;
            base   = 15'd7680;
        end
        else if (hue_s1_reg >= 15'd3840)
        begin
            sector = SEC_YEL_GRN;
            base   = 15'd3840;
        end
        else
        begin
            sector = SEC_RED_YEL;
            base   = 15'd0;
        end
        pos       = hue_s1_reg - base;
        frac      = pos[11:0];
        // rising component loses (3840 - f), falling one loses f
        rise_loss = hsv_pkg::SECTOR_UNITS - frac;

        unique case (sector)
            SEC_RED_YEL:
            begin
                loss_r_next = '0;
                loss_g_next = rise_loss;
                loss_b_next = hsv_pkg::SECTOR_UNITS;
            end
            SEC_YEL_GRN:
            begin
                loss_r_next = frac;
                loss_g_next = '0;
                loss_b_next = hsv_pkg::SECTOR_UNITS;
            end
            SEC_GRN_CYN:
            begin
                loss_r_next = hsv_pkg::SECTOR_UNITS;
                loss_g_next = '0;
                loss_b_next = rise_loss;
            end
            SEC_CYN_BLU:
            begin
                loss_r_next = hsv_pkg::SECTOR_UNITS;
                loss_g_next = frac;
                loss_b_next = '0;
            end
            SEC_BLU_MAG:
            begin
                loss_r_next = rise_loss;
                loss_g_next = hsv_pkg::SECTOR_UNITS;
                loss_b_next = '0;
            end
            default:
            begin
                loss_r_next = '0;
                loss_g_next = hsv_pkg::SECTOR_UNITS;
                loss_b_next = frac;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_s1_reg  <= 1'b0;
            vld_s2_reg  <= 1'b0;
            vld_dly_reg <= '0;
        end
        else
        begin
            vld_s1_reg  <= start && !busy;
            vld_s2_reg  <= vld_s1_reg;
            vld_dly_reg <= {vld_dly_reg[NDLY-2:0], vld_s2_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        hue_s1_reg    <= hue_next;
        sat_s1_reg    <= saturation;
        val_s1_reg    <= brightness;
        alpha_s1_reg  <= alpha_in;
        sat_s2_reg    <= sat_s1_reg;
        val_s2_reg    <= val_s1_reg;
        alpha_s2_reg  <= alpha_s1_reg;
        loss_r_s2_reg <= loss_r_next;
        loss_g_s2_reg <= loss_g_next;
        loss_b_s2_reg <= loss_b_next;
        alpha_dly_reg[0] <= alpha_s2_reg;
        for (int i = 1; i < NDLY; i++)
        begin
            alpha_dly_reg[i] <= alpha_dly_reg[i-1];
        end
    end

    hsv_chan_scale u_red
    (
        .clk  (clk),
        .sat  (sat_s2_reg),
        .val  (val_s2_reg),
        .loss (loss_r_s2_reg),
        .chan (red)
    );

    hsv_chan_scale u_green
    (
        .clk  (clk),
        .sat  (sat_s2_reg),
        .val  (val_s2_reg),
        .loss (loss_g_s2_reg),
        .chan (green)
    );

    hsv_chan_scale u_blue
    (
        .clk  (clk),
        .sat  (sat_s2_reg),
        .val  (val_s2_reg),
        .loss (loss_b_s2_reg),
        .chan (blue)
    );

    assign done      = vld_dly_reg[NDLY-1];
    assign alpha_out = alpha_dly_reg[NDLY-1];

    `HSV_ASSERT_NEVER(a_never_busy, clk, rst_n, busy)
    `HSV_ASSERT_IMPLIES(a_done_has_start, clk, rst_n, done, $past(start, LAT))
    `HSV_ASSERT_IMPLIES(a_chan_le_val, clk, rst_n, done, (red <= $past(brightness, LAT)) && (green <= $past(brightness, LAT)) && (blue <= $past(brightness, LAT)))
    `HSV_ASSERT_IMPLIES(a_gray_exact, clk, rst_n, done && ($past(saturation, LAT) == 8'd0), (red == $past(brightness, LAT)) && (green == red) && (blue == red))

endmodule

`default_nettype wire
